// ===== hdl/cgd_pkg.sv =====
package cgd_pkg;

    localparam int CHAR_W = 7;
    localparam int KEPT_W = 9;
    localparam int CCNT_W = 8;
    localparam int SEQ_W  = 9;
    localparam int DICT_W = 7;
    localparam int CFG_W  = 9;
    localparam int ADDR_W = 2;

    // event queue depth, power of two
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ADDR_W-1:0] REG_CLASS_COUNT = 2'd0;
    localparam logic [ADDR_W-1:0] REG_SEQ_LENGTH  = 2'd1;
    localparam logic [ADDR_W-1:0] REG_DICT_SIZE   = 2'd2;

    localparam logic [CCNT_W-1:0] CLASS_COUNT_RST = 8'd128;
    localparam logic [SEQ_W-1:0]  SEQ_LENGTH_RST  = 9'd256;
    localparam logic [DICT_W-1:0] DICT_SIZE_RST   = 7'd127;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic              has_char;
        logic              is_end;
        logic [CHAR_W-1:0] pos;
        logic [KEPT_W-1:0] kept;
    } evt_ctl_t;

endpackage

// ===== hdl/ctc_greedy_decoder.sv =====
// CTC greedy decoder. Scores stream in one per clock, class by class and step by step; the
// front end tracks the row maximum, collapses blanks and repeats and accumulates the kept
// score sum, taking one score every cycle while its four-word event queue has room. Only a
// row that yields a character or ends a sequence posts an event. The back end emits a
// character word for an event that carries one and a summary word for one that ends a
// sequence; the summary mean comes from the serial restoring divide of the sum by the kept
// count, one quotient bit per cycle (no divide, and a zero mean, when nothing was kept);
// results leave through a registered output stage.
module ctc_greedy_decoder #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_STEPS   = 256,
    parameter int SCORE_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_en,
    input  logic [cgd_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [cgd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SCORE_BITS-1:0] score,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [cgd_pkg::CHAR_W-1:0]   char_pos,
    output logic [cgd_pkg::KEPT_W-1:0]   kept_count,
    output logic signed [SCORE_BITS-1:0] mean_conf,
    output logic                         last
);
    import cgd_pkg::*;

    localparam int SUM_W = SCORE_BITS + KEPT_W;
    localparam int QW    = $bits(evt_ctl_t) + SUM_W;

    logic                    q_full;
    logic                    q_empty;
    logic                    push;
    logic                    pop;
    evt_ctl_t                push_ctl;
    logic signed [SUM_W-1:0] push_sum;
    logic [QW-1:0]           q_data;
    evt_ctl_t                q_ctl;
    logic signed [SUM_W-1:0] q_sum;

    assign q_ctl = evt_ctl_t'(q_data[QW-1:SUM_W]);
    assign q_sum = signed'(q_data[SUM_W-1:0]);

    cgd_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS),
        .SCORE_BITS  (SCORE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_en   (cfg_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .score    (score),
        .q_full   (q_full),
        .push     (push),
        .push_ctl (push_ctl),
        .push_sum (push_sum)
    );

    cgd_queue #(
        .W (QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({push_ctl, push_sum}),
        .full    (q_full),
        .pop     (pop),
        .empty   (q_empty),
        .rd_data (q_data)
    );

    cgd_back #(
        .SCORE_BITS (SCORE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .pop        (pop),
        .q_ctl      (q_ctl),
        .q_sum      (q_sum),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .char_pos   (char_pos),
        .kept_count (kept_count),
        .mean_conf  (mean_conf),
        .last       (last)
    );

endmodule

// ===== hdl/cgd_front.sv =====
module cgd_front #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_STEPS   = 256,
    parameter int SCORE_BITS  = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_en,
    input  logic [cgd_pkg::ADDR_W-1:0]               cfg_addr,
    input  logic [cgd_pkg::CFG_W-1:0]                cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [SCORE_BITS-1:0]             score,
    input  logic                                     q_full,
    output logic                                     push,
    output cgd_pkg::evt_ctl_t                        push_ctl,
    output logic signed [SCORE_BITS+cgd_pkg::KEPT_W-1:0] push_sum
);
    import cgd_pkg::*;

    localparam int CLS_LIM = (MAX_CLASSES < 255) ? MAX_CLASSES : 255;
    localparam int CLS_W   = $clog2(CLS_LIM);
    localparam int STP_LIM = (MAX_STEPS < 511) ? MAX_STEPS : 511;
    localparam int STP_W   = (STP_LIM > 1) ? $clog2(STP_LIM) : 1;
    localparam int SUM_W   = SCORE_BITS + KEPT_W;
    localparam logic [CCNT_W-1:0] CLS_LIM_C = CCNT_W'(CLS_LIM);
    localparam logic [SEQ_W-1:0]  STP_LIM_C = SEQ_W'(STP_LIM);

    logic [CCNT_W-1:0]            class_count_reg;
    logic [SEQ_W-1:0]             seq_length_reg;
    logic [DICT_W-1:0]            dict_size_reg;

    logic [CLS_W-1:0]             class_pos_reg, class_pos_next;
    logic [STP_W-1:0]             step_pos_reg, step_pos_next;
    logic [CLS_W-1:0]             best_class_reg, best_class_next;
    logic signed [SCORE_BITS-1:0] best_score_reg, best_score_next;
    logic [CLS_W-1:0]             prev_class_reg, prev_class_next;
    logic                         prev_valid_reg, prev_valid_next;
    logic signed [SUM_W-1:0]      acc_sum_reg, acc_sum_next;
    logic [KEPT_W-1:0]            kept_reg, kept_next;

    logic                         accept;
    logic [CCNT_W-1:0]            ncls;
    logic [SEQ_W-1:0]             nstp;
    logic                         take;
    logic signed [SCORE_BITS-1:0] bs_new;
    logic [CLS_W-1:0]             bc_new;
    logic                         row_end;
    logic                         last_step;
    logic                         keep;
    logic [KEPT_W-1:0]            pos_full;
    logic                         in_char;
    logic signed [SUM_W-1:0]      sum_new;
    logic [KEPT_W-1:0]            kept_new;
    logic                         seq_end;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (class_count_reg == '0)
            ncls = CCNT_W'(1);
        else if (class_count_reg > CLS_LIM_C)
            ncls = CLS_LIM_C;
        else
            ncls = class_count_reg;

        if (seq_length_reg == '0)
            nstp = SEQ_W'(1);
        else if (seq_length_reg > STP_LIM_C)
            nstp = STP_LIM_C;
        else
            nstp = seq_length_reg;

        take      = (class_pos_reg == '0) || (score > best_score_reg);
        bs_new    = take ? score : best_score_reg;
        bc_new    = take ? class_pos_reg : best_class_reg;
        row_end   = ((CCNT_W+1)'(class_pos_reg) + (CCNT_W+1)'(1)) >= {1'b0, ncls};
        last_step = ((SEQ_W+1)'(step_pos_reg) + (SEQ_W+1)'(1)) >= {1'b0, nstp};
        keep      = (bc_new != '0) && !(prev_valid_reg && (prev_class_reg == bc_new));
        pos_full  = KEPT_W'(bc_new) - KEPT_W'(1);
        in_char   = keep && (pos_full < KEPT_W'(dict_size_reg));
        sum_new   = keep ? (acc_sum_reg + SUM_W'(bs_new)) : acc_sum_reg;
        kept_new  = kept_reg + KEPT_W'(keep);
        seq_end   = row_end && last_step;

        push              = accept && row_end && (in_char || seq_end);
        push_ctl.has_char = in_char;
        push_ctl.is_end   = seq_end;
        push_ctl.pos      = pos_full[CHAR_W-1:0];
        push_ctl.kept     = kept_new;
        push_sum          = sum_new;

        class_pos_next  = class_pos_reg;
        step_pos_next   = step_pos_reg;
        best_class_next = best_class_reg;
        best_score_next = best_score_reg;
        prev_class_next = prev_class_reg;
        prev_valid_next = prev_valid_reg;
        acc_sum_next    = acc_sum_reg;
        kept_next       = kept_reg;

        if (accept)
        begin
            best_class_next = bc_new;
            best_score_next = bs_new;
            if (!row_end)
                class_pos_next = class_pos_reg + CLS_W'(1);
            else
            begin
                class_pos_next = '0;
                if (seq_end)
                begin
                    step_pos_next   = '0;
                    best_class_next = '0;
                    best_score_next = '0;
                    prev_class_next = '0;
                    prev_valid_next = 1'b0;
                    acc_sum_next    = '0;
                    kept_next       = '0;
                end
                else
                begin
                    step_pos_next   = step_pos_reg + STP_W'(1);
                    prev_class_next = bc_new;
                    prev_valid_next = 1'b1;
                    acc_sum_next    = sum_new;
                    kept_next       = kept_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= CLASS_COUNT_RST;
            seq_length_reg  <= SEQ_LENGTH_RST;
            dict_size_reg   <= DICT_SIZE_RST;
            class_pos_reg   <= '0;
            step_pos_reg    <= '0;
            best_class_reg  <= '0;
            best_score_reg  <= '0;
            prev_class_reg  <= '0;
            prev_valid_reg  <= 1'b0;
            acc_sum_reg     <= '0;
            kept_reg        <= '0;
        end
        else
        begin
            if (cfg_en)
            begin
                case (cfg_addr)
                    REG_CLASS_COUNT: class_count_reg <= cfg_data[CCNT_W-1:0];
                    REG_SEQ_LENGTH:  seq_length_reg  <= cfg_data[SEQ_W-1:0];
                    REG_DICT_SIZE:   dict_size_reg   <= cfg_data[DICT_W-1:0];
                    default:         ;
                endcase
            end
            class_pos_reg  <= class_pos_next;
            step_pos_reg   <= step_pos_next;
            best_class_reg <= best_class_next;
            best_score_reg <= best_score_next;
            prev_class_reg <= prev_class_next;
            prev_valid_reg <= prev_valid_next;
            acc_sum_reg    <= acc_sum_next;
            kept_reg       <= kept_next;
        end
    end

endmodule

// ===== hdl/cgd_queue.sv =====
module cgd_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rd_data
);
    import cgd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]  mem [QUEUE_DEPTH];
    logic [W-1:0]  rd_data_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full    = count_reg == (PW+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = rd_data_reg;

    // read word is held until the next pop
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
        if (pop)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("word pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("word popped from empty queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + (PW+1)'(1))
        else $error("queue count lost a word");
`endif

endmodule

// ===== hdl/cgd_back.sv =====
module cgd_back #(
    parameter int SCORE_BITS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         q_empty,
    output logic                                         pop,
    input  cgd_pkg::evt_ctl_t                            q_ctl,
    input  logic signed [SCORE_BITS+cgd_pkg::KEPT_W-1:0] q_sum,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic                                         kind,
    output logic [cgd_pkg::CHAR_W-1:0]                   char_pos,
    output logic [cgd_pkg::KEPT_W-1:0]                   kept_count,
    output logic signed [SCORE_BITS-1:0]                 mean_conf,
    output logic                                         last
);
    import cgd_pkg::*;

    localparam int SUM_W = SCORE_BITS + KEPT_W;
    localparam int CNT_W = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHAR,
        B_LOAD,
        B_DIV,
        B_SUM
    } back_state_t;

    back_state_t             st_reg;
    logic [KEPT_W-1:0]       rem_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic                    neg_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    out_valid_reg;
    logic                    kind_reg;
    logic [CHAR_W-1:0]       char_pos_reg;
    logic [KEPT_W-1:0]       kept_count_reg;
    logic signed [SCORE_BITS-1:0] mean_conf_reg;
    logic                    last_reg;

    logic                    out_free;
    logic                    emit_char;
    logic                    emit_sum;
    logic [SUM_W-1:0]        mag;
    logic [KEPT_W:0]         rem_sh;
    logic [KEPT_W:0]         rem_sub;
    logic                    ge;
    logic [KEPT_W-1:0]       rem_nx;
    logic [SUM_W-1:0]        quo_nx;
    logic [SUM_W-1:0]        quo_sgn;

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign char_pos   = char_pos_reg;
    assign kept_count = kept_count_reg;
    assign mean_conf  = mean_conf_reg;
    assign last       = last_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (st_reg == B_IDLE) && !q_empty;
    assign emit_char = (st_reg == B_CHAR) && q_ctl.has_char && out_free;
    assign emit_sum  = (st_reg == B_SUM) && out_free;

    // restoring divide, one quotient bit a cycle
    always_comb
    begin
        mag     = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);
        rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
        rem_sub = rem_sh - {1'b0, q_ctl.kept};
        ge      = rem_sh >= {1'b0, q_ctl.kept};
        rem_nx  = ge ? rem_sub[KEPT_W-1:0] : rem_sh[KEPT_W-1:0];
        quo_nx  = {quo_reg[SUM_W-2:0], ge};
        quo_sgn = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= B_IDLE;
            rem_reg        <= '0;
            quo_reg        <= '0;
            neg_reg        <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_CHAR;
            char_pos_reg   <= '0;
            kept_count_reg <= '0;
            mean_conf_reg  <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (emit_char || emit_sum)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (st_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                        st_reg <= B_CHAR;
                end
                B_CHAR:
                begin
                    if (!q_ctl.has_char)
                        st_reg <= B_LOAD;
                    else if (out_free)
                    begin
                        kind_reg       <= KIND_CHAR;
                        char_pos_reg   <= q_ctl.pos;
                        kept_count_reg <= '0;
                        mean_conf_reg  <= '0;
                        last_reg       <= 1'b0;
                        st_reg         <= q_ctl.is_end ? B_LOAD : B_IDLE;
                    end
                end
                B_LOAD:
                begin
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(SUM_W);
                    if (q_ctl.kept == '0)
                    begin
                        quo_reg <= '0;
                        neg_reg <= 1'b0;
                        st_reg  <= B_SUM;
                    end
                    else
                    begin
                        quo_reg <= mag;
                        neg_reg <= q_sum[SUM_W-1];
                        st_reg  <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    rem_reg <= rem_nx;
                    quo_reg <= quo_nx;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        st_reg <= B_SUM;
                end
                B_SUM:
                begin
                    if (out_free)
                    begin
                        kind_reg       <= KIND_SUMMARY;
                        char_pos_reg   <= '0;
                        kept_count_reg <= q_ctl.kept;
                        mean_conf_reg  <= quo_sgn[SCORE_BITS-1:0];
                        last_reg       <= 1'b1;
                        st_reg         <= B_IDLE;
                    end
                end
                default:
                    st_reg <= B_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == B_DIV) |-> (q_ctl.kept != '0))
        else $error("divide started with zero kept count");
    a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == (kind_reg == KIND_SUMMARY)))
        else $error("last flag does not match word kind");
    a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg
            && $stable({kind_reg, char_pos_reg, kept_count_reg, mean_conf_reg, last_reg})))
        else $error("output word changed while waiting");
`endif

endmodule
